// ===== rtl/eod_pkg.sv =====
// Package for the elevator order dispatcher.
// Holds the operation and direction codes, the order bit layout and the beat types.
// No dependencies.
package eod_pkg;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int LAMP_FLOORS = 4;

   localparam logic [1:0] FUNC_LATCH = 2'd0;
   localparam logic [1:0] FUNC_CLEAR_FLOOR = 2'd1;
   localparam logic [1:0] FUNC_CLEAR_ALL = 2'd2;
   localparam logic [1:0] FUNC_QUERY = 2'd3;

   localparam logic [1:0] DIR_UP = 2'b01;
   localparam logic [1:0] DIR_DOWN = 2'b11;

   localparam int BIT_UP = 0;
   localparam int BIT_DOWN = 1;
   localparam int BIT_CAB = 2;

   localparam logic [2:0] NO_TARGET = 3'b111;

   typedef logic [2:0] order_type;

   typedef struct packed {
      logic [2:0] sensor_floor;
      logic [1:0] travel_dir;
      logic [1:0] car_floor;
      logic cab_pressed;
      logic hall_down_pressed;
      logic hall_up_pressed;
      logic [1:0] floor;
      logic [1:0] func;
   } req_type;

   typedef struct packed {
      logic [11:0] order_lamps;
      logic any_orders;
      logic stop_here;
      logic next_up;
      logic target_found;
      logic [2:0] goal_floor;
   } rsp_type;

endpackage

// ===== rtl/eod_table.sv =====
// Order table of the elevator order dispatcher: one up, down and cab bit per floor.
// Applies latch and clear operations and shows the updated table. Depends on eod_pkg.
module eod_table #(
   parameter int FLOOR_COUNT = 4
) (
   input logic clock,
   input logic reset,
   input logic upd_en,
   input eod_pkg::req_type req,
   output eod_pkg::order_type [FLOOR_COUNT-1:0] tbl_upd
);

   eod_pkg::order_type [FLOOR_COUNT-1:0] tbl_ff;
   eod_pkg::order_type [FLOOR_COUNT-1:0] tbl_in;

   always_comb begin
      tbl_in = tbl_ff;
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         if (req.func == eod_pkg::FUNC_CLEAR_ALL) begin
            tbl_in[i] = '0;
         end else if (32'(req.floor) == i) begin
            if (req.func == eod_pkg::FUNC_CLEAR_FLOOR) begin
               tbl_in[i] = '0;
            end else if (req.func == eod_pkg::FUNC_LATCH) begin
               if (req.hall_up_pressed && i != FLOOR_COUNT - 1) begin
                  tbl_in[i][eod_pkg::BIT_UP] = 1'b1;
               end
               if (req.hall_down_pressed && i != 0) begin
                  tbl_in[i][eod_pkg::BIT_DOWN] = 1'b1;
               end
               if (req.cab_pressed) begin
                  tbl_in[i][eod_pkg::BIT_CAB] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_ff <= '0;
      end else if (upd_en) begin
         tbl_ff <= tbl_in;
      end
   end

   assign tbl_upd = tbl_in;

endmodule

// ===== rtl/eod_search.sv =====
// Dispatch search of the elevator order dispatcher: picks the next floor to serve
// from the order table, car position and direction. Depends on eod_pkg.
module eod_search #(
   parameter int FLOOR_COUNT = 4
) (
   input eod_pkg::order_type [FLOOR_COUNT-1:0] tbl,
   input eod_pkg::req_type req,
   output eod_pkg::rsp_type rsp
);

   localparam int IDX_W = $clog2(FLOOR_COUNT);
   localparam int CMP_W = (IDX_W > 2) ? IDX_W : 2;

   logic [IDX_W-1:0] cur;
   logic [FLOOR_COUNT-1:0] hit_up_a;
   logic [FLOOR_COUNT-1:0] hit_up_b;
   logic [FLOOR_COUNT-1:0] hit_dn_a;
   logic [FLOOR_COUNT-1:0] hit_dn_b;
   logic [IDX_W-1:0] up_a_idx;
   logic [IDX_W-1:0] up_b_idx;
   logic [IDX_W-1:0] dn_a_idx;
   logic [IDX_W-1:0] dn_b_idx;
   logic up_found;
   logic dn_found;
   logic [IDX_W-1:0] up_idx;
   logic [IDX_W-1:0] dn_idx;
   logic [IDX_W-1:0] tgt_idx;
   logic found;
   logic any;
   logic [11:0] lamps;

   function automatic logic [IDX_W-1:0] lowest(input logic [FLOOR_COUNT-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [IDX_W-1:0] highest(input logic [FLOOR_COUNT-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         if (v[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   always_comb begin
      if (32'(req.car_floor) > 32'(FLOOR_COUNT - 1)) begin
         cur = IDX_W'(FLOOR_COUNT - 1);
      end else begin
         cur = IDX_W'(req.car_floor);
      end
   end

   always_comb begin
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         hit_up_a[i] = (i >= int'(cur)) &&
            (tbl[i][eod_pkg::BIT_UP] || tbl[i][eod_pkg::BIT_CAB]);
         hit_up_b[i] = (i >= int'(cur)) && tbl[i][eod_pkg::BIT_DOWN];
         hit_dn_a[i] = (i <= int'(cur)) &&
            (tbl[i][eod_pkg::BIT_DOWN] || tbl[i][eod_pkg::BIT_CAB]);
         hit_dn_b[i] = (i < int'(cur)) && tbl[i][eod_pkg::BIT_UP];
      end
   end

   assign up_a_idx = lowest(hit_up_a);
   assign up_b_idx = highest(hit_up_b);
   assign dn_a_idx = highest(hit_dn_a);
   assign dn_b_idx = lowest(hit_dn_b);
   assign up_found = (|hit_up_a) || (|hit_up_b);
   assign dn_found = (|hit_dn_a) || (|hit_dn_b);
   assign up_idx = (|hit_up_a) ? up_a_idx : up_b_idx;
   assign dn_idx = (|hit_dn_a) ? dn_a_idx : dn_b_idx;

   assign any = |tbl;

   always_comb begin
      found = 1'b0;
      tgt_idx = '0;
      if (any) begin
         if (req.travel_dir == eod_pkg::DIR_UP) begin
            found = up_found || dn_found;
            tgt_idx = up_found ? up_idx : dn_idx;
         end else if (req.travel_dir == eod_pkg::DIR_DOWN) begin
            found = up_found || dn_found;
            tgt_idx = dn_found ? dn_idx : up_idx;
         end
      end
   end

   always_comb begin
      lamps = '0;
      for (int f = 0; f < eod_pkg::LAMP_FLOORS; f++) begin
         if (f < FLOOR_COUNT) begin
            lamps[3*f +: 3] = tbl[f];
         end
      end
   end

   always_comb begin
      rsp.order_lamps = lamps;
      rsp.any_orders = any;
      rsp.target_found = found;
      if (found) begin
         rsp.goal_floor = 3'(tgt_idx);
         rsp.next_up = (tgt_idx >= cur);
         rsp.stop_here = !req.sensor_floor[2] &&
            (CMP_W'(tgt_idx) == CMP_W'(req.sensor_floor[1:0]));
      end else begin
         rsp.goal_floor = eod_pkg::NO_TARGET;
         rsp.next_up = 1'b0;
         rsp.stop_here = (req.sensor_floor == eod_pkg::NO_TARGET);
      end
   end

endmodule

// ===== rtl/elevator_order_dispatcher_top.sv =====
// Elevator order dispatcher: an accepted request beat goes through the input register,
// then the result register, to its response beat; a stall holds it. Throughput is one
// beat per cycle when the output does not stall; the table update and dispatch search
// share one stage between both registers; each beat sees the table the last beat left.
// Reset (synchronous, active high) clears the order table and both valid flags.
// Depends on eod_pkg, eod_table and eod_search.
module elevator_order_dispatcher_top #(
   parameter int FLOOR_COUNT = 4
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // From bit 0: func[2], floor[2], hall_up_pressed, hall_down_pressed, cab_pressed,
   // car_floor[2], travel_dir[2], sensor_floor[3], zero fill[2].
   input logic [eod_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // From bit 0: goal_floor[3], target_found, next_up, stop_here, any_orders,
   // order_lamps[12], zero fill[5].
   output logic [eod_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int REQ_W = $bits(eod_pkg::req_type);
   localparam int RSP_W = $bits(eod_pkg::rsp_type);

   logic in_vld_ff;
   logic in_vld_in;
   eod_pkg::req_type in_pl_ff;
   eod_pkg::req_type in_pl_in;
   logic out_vld_ff;
   logic out_vld_in;
   eod_pkg::rsp_type out_pl_ff;
   eod_pkg::rsp_type out_pl_in;
   logic adv;
   logic req_take;
   eod_pkg::order_type [FLOOR_COUNT-1:0] tbl_upd;
   eod_pkg::rsp_type result;

   assign adv = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      in_pl_in = in_pl_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
         in_pl_in = req_tdata[REQ_W-1:0];
      end else if (adv) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      out_pl_in = out_pl_ff;
      if (adv) begin
         out_vld_in = 1'b1;
         out_pl_in = result;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_pl_ff <= in_pl_in;
      out_pl_ff <= out_pl_in;
   end

   eod_table #(
      .FLOOR_COUNT(FLOOR_COUNT)
   ) u_table (
      .clock(clock),
      .reset(reset),
      .upd_en(adv),
      .req(in_pl_ff),
      .tbl_upd(tbl_upd)
   );

   eod_search #(
      .FLOOR_COUNT(FLOOR_COUNT)
   ) u_search (
      .tbl(tbl_upd),
      .req(in_pl_ff),
      .rsp(result)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {{(eod_pkg::RSP_DATA_W - RSP_W){1'b0}}, out_pl_ff};

`ifndef SYNTH
   // A stalled request must stay in the input register until it moves on.
   assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !adv |=> in_vld_ff && $stable(in_pl_ff))
      else $error("input register lost or changed a stalled beat");

   // Clearing all floors leaves an empty table in the response.
   assert property (@(posedge clock) disable iff (reset)
      adv && in_pl_ff.func == eod_pkg::FUNC_CLEAR_ALL
      |=> out_pl_ff.order_lamps == 12'd0 && !out_pl_ff.any_orders)
      else $error("clear all left orders in the table");

   // A target can only be found when some order is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_pl_ff.target_found |-> out_pl_ff.any_orders)
      else $error("target found with an empty table");

   // Without a target the response clears next_up and gives NO_TARGET as the goal floor.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_pl_ff.target_found
      |-> !out_pl_ff.next_up && out_pl_ff.goal_floor == eod_pkg::NO_TARGET)
      else $error("missing target not reported consistently");
`endif

endmodule
